/* rtl/lut3d_trilinear_color_map_unit_macros.svh */
// Assertion helpers for the color map unit.
`ifndef LUT3D_TRILINEAR_COLOR_MAP_UNIT_MACROS_SVH
`define LUT3D_TRILINEAR_COLOR_MAP_UNIT_MACROS_SVH

// Property that holds at every edge outside reset.
`define LUT3D_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lut3d check failed");

// Implication into the next cycle.
`define LUT3D_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("lut3d check failed");

`endif

/* rtl/lut3d_pkg.sv */
package lut3d_pkg;

  localparam int VW = 18;  // stored entry value width
  localparam int WW = 17;  // Q16 weight, 0..65536
  localparam int PW = 37;  // (b-a)*w product width

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef logic signed [VW-1:0] val_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic [WW-1:0]        wgt_t;

  typedef struct packed {
    wgt_t w0;
    wgt_t w1;
    wgt_t w2;
  } weights_t;

  // (b - a) * w, first half of one blend step
  function automatic prod_t blend_mul(val_t a, val_t b, wgt_t w);
    logic signed [VW:0] diff;
    logic signed [WW:0] ws;
    diff = (VW+1)'(b) - (VW+1)'(a);
    ws   = signed'({1'b0, w});
    return diff * ws;
  endfunction

  // floor((a*65536 + p) / 65536); result lies between a and b
  function automatic val_t blend_add(val_t a, prod_t p);
    logic signed [PW:0] sum;
    sum = ((PW+1)'(a) <<< 16) + (PW+1)'(p);
    return sum[VW+15:16];
  endfunction

  function automatic logic [15:0] clamp16(val_t v);
    logic [15:0] r;
    if (v < 0) begin
      r = 16'h0000;
    end else if (v > val_t'(65535)) begin
      r = 16'hFFFF;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

/* rtl/lut3d_trilinear_color_map_unit.sv */
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall   | opcode, pixel_c0..c2, entry_index, entry_v0..v2
// out     | output    | out_valid/out_stall | out_c0..out_c2
//
// One item per clock while no stalled result holds the pipeline; a pixel result
// passes through 11 register stages and leaves at the next edge without stall.
// Cube writes take one pipeline slot and give no result; they reach the store
// in the same pipeline stage where pixels read it, so all accesses keep item order.
// Reset (rst_n, synchronous) clears the pipeline valids only; the cube is
// undefined until written.
// A stalled result freezes the whole pipeline, so in_stall follows out_stall while out_valid is high.
module lut3d_trilinear_color_map_unit #(
  parameter int CUBE_SIZE = 33
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [15:0] in_pixel_c0,
  input  logic [15:0] in_pixel_c1,
  input  logic [15:0] in_pixel_c2,
  input  logic [15:0] in_entry_index,
  input  logic signed [17:0] in_entry_v0,
  input  logic signed [17:0] in_entry_v1,
  input  logic signed [17:0] in_entry_v2,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_c0,
  output logic [15:0] out_c1,
  output logic [15:0] out_c2
);

  localparam int NN      = CUBE_SIZE * CUBE_SIZE;
  localparam int ENTRIES = NN * CUBE_SIZE;
  localparam int AW      = $clog2(ENTRIES);
  localparam int IW      = $clog2(CUBE_SIZE);
  localparam int TW      = 16 + $clog2(CUBE_SIZE);
  localparam int DW      = 3 * lut3d_pkg::VW;

  // Whole pipeline moves together unless the output holds a stalled result.
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Stage valids; index = stage number.
  logic [11:1] vld_r;
  logic [11:1] vld_nxt;
  logic [3:1]  op_r;

  // Write path through stage 3.
  logic [15:0]   widx_r [1:3];
  logic [DW-1:0] wdat_r [1:3];

  // Stage 1: t = p*(N-1)
  logic [TW-1:0] t_r [3];
  // Stage 2: cell and weight
  logic [IW-1:0] cell_r [3];
  lut3d_pkg::weights_t wt_r [2:8];
  // Stage 3: the eight neighbour addresses
  logic [AW-1:0] addr_r [8];
  // Stage 4: neighbour entries, one per store copy
  logic [DW-1:0] rd_r [8];
  // Blend stages
  lut3d_pkg::prod_t p1_r [4][3];
  lut3d_pkg::val_t  a1_r [4][3];
  lut3d_pkg::val_t  l1_r [4][3];
  lut3d_pkg::prod_t p2_r [2][3];
  lut3d_pkg::val_t  a2_r [2][3];
  lut3d_pkg::val_t  l2_r [2][3];
  lut3d_pkg::prod_t p3_r [3];
  lut3d_pkg::val_t  a3_r [3];
  lut3d_pkg::val_t  l3_r [3];
  logic [15:0] oc0_r, oc1_r, oc2_r;

  // Control
  always_comb begin
    vld_nxt     = vld_r;
    vld_nxt[1]  = in_valid;
    vld_nxt[2]  = vld_r[1];
    vld_nxt[3]  = vld_r[2];
    vld_nxt[4]  = vld_r[3] && (op_r[3] == lut3d_pkg::OP_PIXEL);
    for (int s = 5; s <= 11; s++) begin
      vld_nxt[s] = vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  // Split one channel into cell index and Q16 weight.
  // q = floor(t/65535) via (t + (t>>16) + 1) >> 16, exact for this range.
  logic [IW-1:0] cell_nxt [3];
  lut3d_pkg::wgt_t w_nxt [3];
  always_comb begin
    logic [TW:0]   q;
    logic [IW-1:0] c;
    logic [TW:0]   rem;
    for (int k = 0; k < 3; k++) begin
      q = ((TW+1)'(t_r[k]) + (TW+1)'(t_r[k] >> 16) + (TW+1)'(1)) >> 16;
      if (q > (TW+1)'(CUBE_SIZE - 2)) begin
        c = IW'(CUBE_SIZE - 2);
      end else begin
        c = q[IW-1:0];
      end
      rem = (TW+1)'(t_r[k]) - (((TW+1)'(c) << 16) - (TW+1)'(c));
      cell_nxt[k] = c;
      // rem*65536/65535 = rem, plus one at the top edge
      w_nxt[k] = {1'b0, rem[15:0]} + lut3d_pkg::wgt_t'(rem[15:0] == 16'hFFFF);
    end
  end

  logic [AW-1:0] base;
  assign base = AW'(cell_r[0]) * AW'(NN) + AW'(cell_r[1]) * AW'(CUBE_SIZE)
              + AW'(cell_r[2]);

  // Payload pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1
      op_r[1]   <= in_opcode;
      widx_r[1] <= in_entry_index;
      wdat_r[1] <= {in_entry_v2, in_entry_v1, in_entry_v0};
      t_r[0]    <= TW'(in_pixel_c0) * TW'(CUBE_SIZE - 1);
      t_r[1]    <= TW'(in_pixel_c1) * TW'(CUBE_SIZE - 1);
      t_r[2]    <= TW'(in_pixel_c2) * TW'(CUBE_SIZE - 1);
      // stage 2
      op_r[2]   <= op_r[1];
      widx_r[2] <= widx_r[1];
      wdat_r[2] <= wdat_r[1];
      for (int k = 0; k < 3; k++) begin
        cell_r[k] <= cell_nxt[k];
      end
      wt_r[2] <= '{w0: w_nxt[0], w1: w_nxt[1], w2: w_nxt[2]};
      // stage 3
      op_r[3]   <= op_r[2];
      widx_r[3] <= widx_r[2];
      wdat_r[3] <= wdat_r[2];
      for (int n = 0; n < 8; n++) begin
        addr_r[n] <= base + (n[2] ? AW'(NN) : '0) + (n[1] ? AW'(CUBE_SIZE) : '0)
                   + AW'(n[0]);
      end
      for (int s = 3; s <= 8; s++) begin
        wt_r[s] <= wt_r[s-1];
      end
      // stage 5: along channel 0; neighbour {d0,j}
      for (int j = 0; j < 4; j++) begin
        for (int ch = 0; ch < 3; ch++) begin
          a1_r[j][ch] <= rd_r[j][ch*lut3d_pkg::VW +: lut3d_pkg::VW];
          p1_r[j][ch] <= lut3d_pkg::blend_mul(
              rd_r[j][ch*lut3d_pkg::VW +: lut3d_pkg::VW],
              rd_r[j+4][ch*lut3d_pkg::VW +: lut3d_pkg::VW], wt_r[4].w0);
        end
      end
      // stage 6
      for (int j = 0; j < 4; j++) begin
        for (int ch = 0; ch < 3; ch++) begin
          l1_r[j][ch] <= lut3d_pkg::blend_add(a1_r[j][ch], p1_r[j][ch]);
        end
      end
      // stage 7: along channel 1
      for (int m = 0; m < 2; m++) begin
        for (int ch = 0; ch < 3; ch++) begin
          a2_r[m][ch] <= l1_r[m][ch];
          p2_r[m][ch] <= lut3d_pkg::blend_mul(l1_r[m][ch], l1_r[m+2][ch], wt_r[6].w1);
        end
      end
      // stage 8
      for (int m = 0; m < 2; m++) begin
        for (int ch = 0; ch < 3; ch++) begin
          l2_r[m][ch] <= lut3d_pkg::blend_add(a2_r[m][ch], p2_r[m][ch]);
        end
      end
      // stage 9: along channel 2
      for (int ch = 0; ch < 3; ch++) begin
        a3_r[ch] <= l2_r[0][ch];
        p3_r[ch] <= lut3d_pkg::blend_mul(l2_r[0][ch], l2_r[1][ch], wt_r[8].w2);
      end
      // stage 10
      for (int ch = 0; ch < 3; ch++) begin
        l3_r[ch] <= lut3d_pkg::blend_add(a3_r[ch], p3_r[ch]);
      end
      // stage 11: clamp, channels reversed
      oc0_r <= lut3d_pkg::clamp16(l3_r[2]);
      oc1_r <= lut3d_pkg::clamp16(l3_r[1]);
      oc2_r <= lut3d_pkg::clamp16(l3_r[0]);
    end
  end

  // Cube store: eight identical copies, one per neighbour, so all eight
  // reads happen in the same cycle. Writes go to every copy.
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  assign wr_en   = adv && vld_r[3] && (op_r[3] == lut3d_pkg::OP_WRITE)
                && (32'(widx_r[3]) < 32'(ENTRIES));
  assign wr_addr = AW'(widx_r[3]);

  for (genvar g = 0; g < 8; g++) begin : g_copy
    logic [DW-1:0] mem [ENTRIES];
    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[wr_addr] <= wdat_r[3];
      end
      if (adv && vld_r[3] && (op_r[3] == lut3d_pkg::OP_PIXEL)) begin
        rd_r[g] <= mem[addr_r[g]];
      end
    end
  end

  assign out_valid = vld_r[11];
  assign out_c0    = oc0_r;
  assign out_c1    = oc1_r;
  assign out_c2    = oc2_r;

`include "lut3d_trilinear_color_map_unit_macros.svh"

  // a cube write never turns into a result
  `LUT3D_ASSERT_NEXT(a_wr_no_result, adv && vld_r[3] && (op_r[3] == lut3d_pkg::OP_WRITE), !vld_r[4])
  // a stall freezes every stage
  `LUT3D_ASSERT_NEXT(a_freeze, !adv, $stable(vld_r))
  // a new result only comes from the last blend stage
  `LUT3D_ASSERT(a_out_src, $rose(out_valid) |-> $past(vld_r[10]))

endmodule
